// File: hdl/lgrs_pkg.sv
// ----------------------------------------------------------------------------
// lgrs_pkg
// Shared types, constants and the B3/S23 rule for the row stencil.
// ----------------------------------------------------------------------------
package lgrs_pkg;

  localparam int MAX_WIDTH = 64;
  localparam int WIDTH_W   = 7;
  localparam int NCNT_W    = 4;

  localparam logic [WIDTH_W-1:0] GRID_WIDTH_RST = WIDTH_W'(MAX_WIDTH);

  localparam logic [NCNT_W-1:0] SURVIVE_LO = NCNT_W'(2);
  localparam logic [NCNT_W-1:0] BIRTH_CNT  = NCNT_W'(3);

  // bits one cell shows to its two neighbors, already width-masked
  typedef struct packed {
    logic up;   // held row above
    logic mid;  // held middle row
    logic row;  // incoming row
    logic up2;  // row above the incoming row when it is the last one
  } tap_t;

  // per-request control broadcast to every cell
  typedef struct packed {
    logic load;   // request accepted this cycle
    logic clear;  // last row, drop held rows afterwards
    logic mv;     // a middle row is held
  } cell_ctrl_t;

  typedef struct packed {
    logic [MAX_WIDTH-1:0] cells;
    logic                 final_row;
  } res_t;

  function automatic logic life_rule(input logic alive, input logic [NCNT_W-1:0] n);
    life_rule = alive ? (n == SURVIVE_LO || n == BIRTH_CNT) : (n == BIRTH_CNT);
  endfunction

endpackage

// File: hdl/lgrs_cell.sv
// ----------------------------------------------------------------------------
// lgrs_cell
// One grid column: holds its bit of the two held rows and evaluates the rule.
// ----------------------------------------------------------------------------
module lgrs_cell import lgrs_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       mask_bit,
  input  logic       row_bit,
  input  tap_t       tap_lo,
  input  tap_t       tap_hi,
  output tap_t       tap,
  output logic       nxt_mid,
  output logic       nxt_last
);

  logic              above_r, above_nxt;
  logic              mid_r, mid_nxt;
  logic [NCNT_W-1:0] n_mid, n_last;

  always_comb begin
    tap.up  = above_r & mask_bit;
    tap.mid = mid_r & mask_bit;
    tap.row = row_bit & mask_bit;
    tap.up2 = ctrl.mv & mid_r & mask_bit;
  end

  // neighbors of the held row, and of the incoming row with an empty row below
  assign n_mid  = NCNT_W'($countones({tap_lo.up, tap.up, tap_hi.up,
                                      tap_lo.row, tap.row, tap_hi.row,
                                      tap_lo.mid, tap_hi.mid}));
  assign n_last = NCNT_W'($countones({tap_lo.up2, tap.up2, tap_hi.up2,
                                      tap_lo.row, tap_hi.row}));

  assign nxt_mid  = life_rule(tap.mid, n_mid) & mask_bit;
  assign nxt_last = life_rule(tap.row, n_last) & mask_bit;

  always_comb begin
    above_nxt = above_r;
    mid_nxt   = mid_r;
    if (ctrl.load) begin
      if (ctrl.clear) begin
        above_nxt = 1'b0;
        mid_nxt   = 1'b0;
      end else begin
        above_nxt = ctrl.mv & mid_r;
        mid_nxt   = row_bit & mask_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    above_r <= above_nxt;
    mid_r   <= mid_nxt;
  end

endmodule

// File: hdl/lgrs_out_queue.sv
// ----------------------------------------------------------------------------
// lgrs_out_queue
// Two-entry result queue; a request may push one or two results at once.
// ----------------------------------------------------------------------------
module lgrs_out_queue import lgrs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic [1:0] push_n,
  input  res_t       push_0,
  input  res_t       push_1,
  output logic       space,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       out_res
);

  res_t       q0_r, q0_nxt;
  res_t       q1_r, q1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid & out_ready;
  // queue must be empty after this cycle's pop to take a request
  assign space     = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);
  assign out_res   = q0_r;

  always_comb begin
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    cnt_nxt = cnt_r;
    if (push) begin
      q0_nxt  = push_0;
      q1_nxt  = push_1;
      cnt_nxt = push_n;
    end else if (pop) begin
      q0_nxt  = q1_r;
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result queue count out of range");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r == 2'd0 || (cnt_r == 2'd1 && pop)))
    else $error("push into occupied queue");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push && cnt_r == 2'd2) |=> (cnt_r == 2'd1 && out_res == $past(q1_r)))
    else $error("second entry lost on pop");

endmodule

// File: hdl/life_generation_row_stencil.sv
// a result is registered in the output queue and appears on out in the cycle after its row request is accepted
// throughput: one row per cycle while the output queue has space; a last row that follows a held row gives two
//   results, which the two-entry output queue drains in turn
// reset: grid width 64, no row held, output queue empty
// ----------------------------------------------------------------------------
// life_generation_row_stencil
// Game of Life B3/S23 generation on a bounded grid, one row per request,
// computed by a row of column cells holding the two previous rows.
// ----------------------------------------------------------------------------
module life_generation_row_stencil import lgrs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [WIDTH_W-1:0]   cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [MAX_WIDTH-1:0] in_row_cells,
  input  logic                 in_last_row,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [MAX_WIDTH-1:0] out_next_cells,
  output logic                 out_final_row
);

  logic [WIDTH_W-1:0]   width_r, width_nxt;
  logic                 mv_r, mv_nxt;
  logic [MAX_WIDTH-1:0] mask;
  logic [MAX_WIDTH-1:0] gen_mid, gen_last;
  tap_t                 taps [MAX_WIDTH];
  cell_ctrl_t           ctrl;
  logic                 accept;
  logic [1:0]           push_n;
  res_t                 push_0, push_1, out_res;

  assign accept = in_valid & in_ready;

  always_comb begin
    for (int k = 0; k < MAX_WIDTH; k++) begin
      mask[k] = (WIDTH_W'(k) < width_r);
    end
  end

  assign ctrl.load  = accept;
  assign ctrl.clear = in_last_row;
  assign ctrl.mv    = mv_r;

  for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_col
    tap_t t_lo, t_hi;
    if (k == 0) begin : g_lo_edge
      assign t_lo = '0;
    end else begin : g_lo
      assign t_lo = taps[k-1];
    end
    if (k == MAX_WIDTH - 1) begin : g_hi_edge
      assign t_hi = '0;
    end else begin : g_hi
      assign t_hi = taps[k+1];
    end
    lgrs_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .mask_bit (mask[k]),
      .row_bit  (in_row_cells[k]),
      .tap_lo   (t_lo),
      .tap_hi   (t_hi),
      .tap      (taps[k]),
      .nxt_mid  (gen_mid[k]),
      .nxt_last (gen_last[k])
    );
  end

  // first result is the held row when there is one, else the last row itself
  always_comb begin
    push_0.cells     = mv_r ? gen_mid : gen_last;
    push_0.final_row = ~mv_r;
    push_1.cells     = gen_last;
    push_1.final_row = 1'b1;
    push_n           = 2'({1'b0, mv_r}) + 2'({1'b0, in_last_row});
  end

  lgrs_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_n    (push_n),
    .push_0    (push_0),
    .push_1    (push_1),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_next_cells = out_res.cells;
  assign out_final_row  = out_res.final_row;

  always_comb begin
    width_nxt = cfg_wr_en ? cfg_wr_data : width_r;
    mv_nxt    = mv_r;
    if (accept) begin
      mv_nxt = ~in_last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= GRID_WIDTH_RST;
      mv_r    <= 1'b0;
    end else begin
      width_r <= width_nxt;
      mv_r    <= mv_nxt;
    end
  end

  a_last_ends_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_row) |=> !mv_r)
    else $error("held row survives the last row");

  a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_row && mv_r) |=> (out_valid && !out_final_row))
    else $error("held row result missing before final row");

  a_first_row_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_last_row && !mv_r) |=> !out_valid)
    else $error("first row produced a result");

endmodule
